/* hw/rtl/fupd_pkg.sv */
// Shared types, status codes and character helpers for the file URI percent decoder.
// No dependencies; every other file of the block refers to this package by scoped name.
package fupd_pkg;

   localparam int CAP_W = 17;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_REMOTE  = 3'd2;
   localparam logic [2:0] ST_BAD_ESC = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_PERCENT = 8'h25;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

   // Expected character of the "file://" prefix; index 7 never matches.
   function automatic logic [8:0] scheme_char(input logic [2:0] idx);
      logic [8:0] r;
      unique case (idx)
         3'd0: r = {1'b1, 8'h66};
         3'd1: r = {1'b1, 8'h69};
         3'd2: r = {1'b1, 8'h6C};
         3'd3: r = {1'b1, 8'h65};
         3'd4: r = {1'b1, 8'h3A};
         3'd5: r = {1'b1, 8'h2F};
         3'd6: r = {1'b1, 8'h2F};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Returns {is_hex, value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

/* hw/rtl/fupd_core.sv */
// Parser state and per-byte decode logic of the file URI percent decoder.
// Depends on fupd_pkg; driven by the input register of the top level.
module fupd_core #(
   parameter int MAX_CAPACITY = 65536
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  fupd_pkg::req_type         item,
   input  logic [fupd_pkg::CAP_W-1:0] capacity,
   output fupd_pkg::result_type      result
);

   localparam int CLOG_MAX = $clog2(MAX_CAPACITY);
   localparam int CNT_W = (CLOG_MAX < fupd_pkg::CAP_W) ? CLOG_MAX : fupd_pkg::CAP_W;
   localparam int CMP_W = fupd_pkg::CAP_W + 1;
   localparam logic [31:0] MAX_WIDE = 32'(MAX_CAPACITY);

   localparam logic [2:0] PH_PREFIX     = 3'd0;
   localparam logic [2:0] PH_AUTH_CHECK = 3'd1;
   localparam logic [2:0] PH_AUTH_SCAN  = 3'd2;
   localparam logic [2:0] PH_PATH       = 3'd3;
   localparam logic [2:0] PH_ESC_HI     = 3'd4;
   localparam logic [2:0] PH_ESC_LO     = 3'd5;

   logic [2:0]       phase_ff,  phase_in;
   logic [2:0]       pidx_ff,   pidx_in;
   logic [3:0]       hi_nib_ff, hi_nib_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic [2:0]       err_ff,    err_in;

   logic [fupd_pkg::CAP_W-1:0] eff_cap;
   logic [2:0]                 err_pre;
   logic [8:0]                 exp_char;
   logic [4:0]                 hex;
   logic                       emit_req;
   logic [7:0]                 emit_byte;
   logic                       full;

   always_comb begin
      if ({{(32 - fupd_pkg::CAP_W){1'b0}}, capacity} > MAX_WIDE) begin
         eff_cap = MAX_WIDE[fupd_pkg::CAP_W-1:0];
      end else begin
         eff_cap = capacity;
      end
   end

   assign full = (CMP_W'(count_ff) + CMP_W'(1)) >= CMP_W'(eff_cap);
   assign exp_char = fupd_pkg::scheme_char(pidx_ff);
   assign hex = fupd_pkg::hex_digit(item.in_byte);

   always_comb begin
      phase_in  = phase_ff;
      pidx_in   = pidx_ff;
      hi_nib_in = hi_nib_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      result    = '0;
      emit_req  = 1'b0;
      emit_byte = item.in_byte;

      // Zero capacity poisons the run unless an error is already held.
      err_pre = err_ff;
      if (err_ff == fupd_pkg::ST_OK && eff_cap == '0) begin
         err_pre = fupd_pkg::ST_INVALID;
      end
      err_in = err_pre;

      if (item.end_marker) begin
         result.valid         = 1'b1;
         result.data.done_res = 1'b1;
         result.data.status   = err_pre;
         if (err_pre == fupd_pkg::ST_OK) begin
            if (phase_ff == PH_PREFIX || phase_ff == PH_AUTH_CHECK
                || phase_ff == PH_AUTH_SCAN) begin
               result.data.status = fupd_pkg::ST_INVALID;
            end else if (phase_ff == PH_ESC_HI || phase_ff == PH_ESC_LO) begin
               result.data.status = fupd_pkg::ST_BAD_ESC;
            end
         end
         phase_in  = PH_PREFIX;
         pidx_in   = '0;
         hi_nib_in = '0;
         count_in  = '0;
         err_in    = fupd_pkg::ST_OK;
      end else if (err_pre == fupd_pkg::ST_OK) begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (!exp_char[8] || item.in_byte != exp_char[7:0]) begin
                  err_in = fupd_pkg::ST_INVALID;
               end else begin
                  pidx_in = pidx_ff + 3'd1;
                  if (pidx_ff == 3'd6) begin
                     phase_in = PH_AUTH_CHECK;
                  end
               end
            end
            PH_AUTH_CHECK: begin
               if (item.in_byte == fupd_pkg::CH_SLASH) begin
                  phase_in = PH_PATH;
                  emit_req = 1'b1;
               end else begin
                  phase_in = PH_AUTH_SCAN;
               end
            end
            PH_AUTH_SCAN: begin
               if (item.in_byte == fupd_pkg::CH_SLASH) begin
                  err_in = fupd_pkg::ST_REMOTE;
               end
            end
            PH_ESC_HI: begin
               if (!hex[4]) begin
                  err_in = fupd_pkg::ST_BAD_ESC;
               end else begin
                  hi_nib_in = hex[3:0];
                  phase_in  = PH_ESC_LO;
               end
            end
            PH_ESC_LO: begin
               if (!hex[4]) begin
                  err_in = fupd_pkg::ST_BAD_ESC;
               end else begin
                  phase_in  = PH_PATH;
                  emit_req  = 1'b1;
                  emit_byte = {hi_nib_ff, hex[3:0]};
               end
            end
            default: begin
               if (item.in_byte == fupd_pkg::CH_PERCENT) begin
                  phase_in = PH_ESC_HI;
               end else begin
                  emit_req = 1'b1;
               end
            end
         endcase

         // Write the byte only while one slot stays free for the terminator.
         if (emit_req) begin
            if (full) begin
               err_in = fupd_pkg::ST_FULL;
            end else begin
               count_in               = count_ff + CNT_W'(1);
               result.valid           = 1'b1;
               result.data.out_byte   = emit_byte;
               result.data.byte_valid = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         pidx_ff   <= '0;
         hi_nib_ff <= '0;
         count_ff  <= '0;
         err_ff    <= fupd_pkg::ST_OK;
      end else if (step) begin
         phase_ff  <= phase_in;
         pidx_ff   <= pidx_in;
         hi_nib_ff <= hi_nib_in;
         count_ff  <= count_in;
         err_ff    <= err_in;
      end
   end

   a_end_rearms : assert property (@(posedge clock) disable iff (reset)
      step && item.end_marker |=> phase_ff == PH_PREFIX && count_ff == '0
                                  && err_ff == fupd_pkg::ST_OK)
      else $error("end marker did not rearm the parser");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      step && !item.end_marker |=>
         count_ff == $past(count_ff) || count_ff == $past(count_ff) + CNT_W'(1))
      else $error("written count moved by more than one");

   a_err_sticky : assert property (@(posedge clock) disable iff (reset)
      err_ff != fupd_pkg::ST_OK && !(step && item.end_marker) |=> err_ff == $past(err_ff))
      else $error("latched error changed before end marker");

   a_byte_clean : assert property (@(posedge clock) disable iff (reset)
      step && result.valid && result.data.byte_valid |=> err_ff == fupd_pkg::ST_OK
                                                         && phase_ff == PH_PATH)
      else $error("byte written outside a clean path phase");

endmodule

/* hw/rtl/fupd_out_reg.sv */
// Result register of the file URI percent decoder: holds one beat until taken.
// Depends on fupd_pkg for the result types.
module fupd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  fupd_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fupd_pkg::rsp_type    rsp_data
);

   logic              valid_ff, valid_in;
   fupd_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = step && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && step && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* hw/rtl/file_uri_percent_decoder.sv */
// Top level of the file URI percent decoder: input register, parser, result register.
// Depends on fupd_pkg, fupd_core and fupd_out_reg.
//
// Usage: feed a URI one byte per req beat (req_data.in_byte, end_marker = 0) and close
// it with one beat that has end_marker = 1. The block checks the "file://" prefix and
// the slash after it, then sends each decoded path byte as an rsp beat with byte_valid
// set; %XY escapes collapse to one byte. The end marker always yields one rsp beat with
// done_res set and the final status (0 ok, 1 invalid, 2 remote authority, 3 bad escape,
// 4 output full). Bytes that decode to nothing (prefix, '%', first escape digit, bytes
// after an error, authority bytes) give no rsp beat.
// Path: a taken req beat sits in the input register, then the parser step loads the
// result register, which drives rsp_valid.
// Throughput: one req beat per cycle while the result register is free to take it, set by
// the combinational parser step between the two registers.
// Stalls: while rsp_ready is low and a result is waiting, the parser holds and req_ready
// drops once the input register is also full; nothing is lost or repeated.
// csr: one write channel (always ready) sets out_capacity, used as
// min(out_capacity, MAX_CAPACITY); write it only while the block is idle.
// Reset: synchronous, clears both registers and the parser; out_capacity returns to 4096.
module file_uri_percent_decoder #(
   parameter int MAX_CAPACITY = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fupd_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fupd_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fupd_pkg::CAP_W-1:0] csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   fupd_pkg::req_type          in_data_ff;
   logic [fupd_pkg::CAP_W-1:0] capacity_ff;
   logic                       step;
   logic                       out_free;
   fupd_pkg::result_type       result;

   // Advance the held beat through the parser whenever the result register can take it.
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Load a new beat only when the old one has moved on.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= fupd_pkg::CAP_W'(4096);
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_wdata;
      end
   end

   fupd_core #(
      .MAX_CAPACITY(MAX_CAPACITY)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (in_data_ff),
      .capacity (capacity_ff),
      .result   (result)
   );

   fupd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for file_uri_percent_decoder: directed and random URIs against an
// in-bench decoder model, with random idling on both channels. Depends on fupd_pkg.
module tb_top;

   localparam int MAX_CAP = 65536;
   localparam int LIMIT_CYCLES = 500000;
   localparam int DRAIN_CYCLES = 8;       // well past the req-to-rsp latency
   localparam int NUM_STAGES = 10;
   localparam int STAGE_ITEMS = 130;
   localparam int MAX_GAP = 18;
   localparam int FREEZE_CYCLES = 400;
   localparam int REPORT_LIMIT = 10;
   localparam logic [55:0] SCHEME = "file://";

   typedef enum logic [2:0] {
      SCAN_PREFIX, AUTH_CHECK, AUTH_SCAN, IN_PATH, ESC_HIGH, ESC_LOW
   } parse_phase_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   fupd_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   fupd_pkg::rsp_type          rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [fupd_pkg::CAP_W-1:0] csr_wdata = '0;

   // URI beats waiting for the sender, and decoder results still owed by the block
   fupd_pkg::req_type uri_beats_queued[$];
   fupd_pkg::rsp_type uri_results_due[$];

   // Bench copy of the decoder state and its capacity register
   logic [fupd_pkg::CAP_W-1:0] capacity_reg = 17'd4096;
   parse_phase_type            parse_phase = SCAN_PREFIX;
   int                         prefix_pos = 0;
   logic [3:0]                 esc_high = '0;
   int                         bytes_written = 0;
   logic [2:0]                 latched_status = fupd_pkg::ST_OK;

   bit tx_gaps = 1'b1;
   bit rx_gaps = 1'b1;
   int tx_wait = 0;
   int rx_wait = 0;
   int rx_freeze = 0;
   int queued_items = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   file_uri_percent_decoder #(
      .MAX_CAPACITY(MAX_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   // Hex digit value, or -1 when the character is not a hex digit (either case).
   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // Advance the decoder model by one accepted beat; queue the result it owes, if any.
   task automatic decode_uri_beat(input fupd_pkg::req_type beat);
      fupd_pkg::rsp_type res;
      int                cap;
      int                digit;
      bit                emit;
      logic [7:0]        emit_byte;
      cap = (int'(capacity_reg) > MAX_CAP) ? MAX_CAP : int'(capacity_reg);
      emit = 1'b0;
      emit_byte = '0;
      // a zero capacity poisons every beat, the end marker included
      if (latched_status == fupd_pkg::ST_OK && cap == 0) latched_status = fupd_pkg::ST_INVALID;
      if (beat.end_marker) begin
         res = '0;
         res.done_res = 1'b1;
         res.status = latched_status;
         if (latched_status == fupd_pkg::ST_OK) begin
            case (parse_phase)
               SCAN_PREFIX, AUTH_CHECK, AUTH_SCAN: res.status = fupd_pkg::ST_INVALID;
               ESC_HIGH, ESC_LOW:                  res.status = fupd_pkg::ST_BAD_ESC;
               default: ;
            endcase
         end
         uri_results_due.push_back(res);
         // rearm for the next URI; capacity stays
         parse_phase = SCAN_PREFIX;
         prefix_pos = 0;
         esc_high = '0;
         bytes_written = 0;
         latched_status = fupd_pkg::ST_OK;
      end else if (latched_status == fupd_pkg::ST_OK) begin
         case (parse_phase)
            SCAN_PREFIX: begin
               if (prefix_pos > 6 || beat.in_byte != SCHEME[(6 - prefix_pos) * 8 +: 8]) begin
                  latched_status = fupd_pkg::ST_INVALID;
               end else begin
                  prefix_pos++;
                  if (prefix_pos == 7) parse_phase = AUTH_CHECK;
               end
            end
            AUTH_CHECK: begin
               if (beat.in_byte == fupd_pkg::CH_SLASH) begin
                  parse_phase = IN_PATH;
                  emit = 1'b1;
                  emit_byte = beat.in_byte;
               end else begin
                  parse_phase = AUTH_SCAN;
               end
            end
            AUTH_SCAN: begin
               if (beat.in_byte == fupd_pkg::CH_SLASH) latched_status = fupd_pkg::ST_REMOTE;
            end
            ESC_HIGH: begin
               digit = hex_value(beat.in_byte);
               if (digit < 0) begin
                  latched_status = fupd_pkg::ST_BAD_ESC;
               end else begin
                  esc_high = digit[3:0];
                  parse_phase = ESC_LOW;
               end
            end
            ESC_LOW: begin
               digit = hex_value(beat.in_byte);
               if (digit < 0) begin
                  latched_status = fupd_pkg::ST_BAD_ESC;
               end else begin
                  parse_phase = IN_PATH;
                  emit = 1'b1;
                  emit_byte = {esc_high, digit[3:0]};
               end
            end
            default: begin
               if (beat.in_byte == fupd_pkg::CH_PERCENT) begin
                  parse_phase = ESC_HIGH;
               end else begin
                  emit = 1'b1;
                  emit_byte = beat.in_byte;
               end
            end
         endcase
         // keep room for the terminator: write only while count + 1 < capacity
         if (emit) begin
            if (bytes_written + 1 >= cap) begin
               latched_status = fupd_pkg::ST_FULL;
            end else begin
               bytes_written++;
               res = '0;
               res.out_byte = emit_byte;
               res.byte_valid = 1'b1;
               res.status = fupd_pkg::ST_OK;
               uri_results_due.push_back(res);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   task automatic push_byte(input logic [7:0] b);
      fupd_pkg::req_type beat;
      beat.in_byte = b;
      beat.end_marker = 1'b0;
      uri_beats_queued.push_back(beat);
      queued_items++;
   endtask

   // The byte field is don't-care on the end marker; randomize it anyway.
   task automatic push_end();
      fupd_pkg::req_type beat;
      beat.in_byte = 8'($urandom);
      beat.end_marker = 1'b1;
      uri_beats_queued.push_back(beat);
      queued_items++;
   endtask

   task automatic push_scheme(input int count);
      for (int i = 0; i < count; i++) push_byte(SCHEME[(6 - i) * 8 +: 8]);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'("0") + 8'(v);
      return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom); while (hex_value(c) >= 0);
      return c;
   endfunction

   function automatic logic [7:0] random_except(input logic [7:0] excluded);
      logic [7:0] c;
      do c = 8'($urandom); while (c == excluded);
      return c;
   endfunction

   // Path body: mostly plain bytes of any value but '%', some well-formed escapes.
   task automatic push_path(input int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            push_byte(fupd_pkg::CH_PERCENT);
            push_byte(hex_char(4'($urandom)));
            push_byte(hex_char(4'($urandom)));
         end else begin
            push_byte(random_except(fupd_pkg::CH_PERCENT));
         end
      end
   endtask

   // One URI: mostly well-formed local paths, the rest broken or hostile shapes.
   task automatic push_random_uri();
      int         kind;
      int         len;
      int         cut;
      logic [7:0] c;
      kind = $urandom_range(0, 99);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
      if (kind < 60) begin
         push_scheme(7);
         push_byte(fupd_pkg::CH_SLASH);
         push_path(len);
         case ($urandom_range(0, 9))
            0: push_byte(fupd_pkg::CH_PERCENT);         // end waiting for high digit
            1: begin                                    // end waiting for low digit
               push_byte(fupd_pkg::CH_PERCENT);
               push_byte(hex_char(4'($urandom)));
            end
            2: begin                                    // non-hex digit inside an escape
               push_byte(fupd_pkg::CH_PERCENT);
               if ($urandom_range(0, 1)) push_byte(hex_char(4'($urandom)));
               push_byte(non_hex_char());
               push_path(2);
            end
            default: ;
         endcase
      end else if (kind < 70) begin
         // authority present, then a slash: remote host
         push_scheme(7);
         push_byte(random_except(fupd_pkg::CH_SLASH));
         for (int i = 0; i < len; i++) push_byte(random_except(fupd_pkg::CH_SLASH));
         push_byte(fupd_pkg::CH_SLASH);
         push_path(2);
      end else if (kind < 76) begin
         // authority with no slash ever
         push_scheme(7);
         push_byte(random_except(fupd_pkg::CH_SLASH));
         for (int i = 0; i < len; i++) push_byte(random_except(fupd_pkg::CH_SLASH));
      end else if (kind < 80) begin
         push_scheme(7);                                // end right after the prefix
      end else if (kind < 90) begin
         cut = $urandom_range(0, 6);
         push_scheme(cut);
         c = random_except(SCHEME[(6 - cut) * 8 +: 8]);
         push_byte(c);
         for (int i = 0; i < len; i++) push_byte(8'($urandom));
      end else if (kind < 95) begin
         push_scheme($urandom_range(0, 6));             // truncated prefix
      end else begin
         for (int i = 0; i < len; i++) push_byte(8'($urandom));
      end
      push_end();
   endtask

   // Sample at the falling edge so the sender's last update has settled.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (uri_beats_queued.size() != 0 || req_valid || uri_results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [fupd_pkg::CAP_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      capacity_reg = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- sender
   // Offer the next queued beat whenever the slot is free; hold valid and payload
   // while the block stalls. Each beat draws the idle cycles that follow it.
   always @(posedge clock) begin : sender
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && req_ready) decode_uri_beat(req_data);
         if (!req_valid || req_ready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (uri_beats_queued.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= uri_beats_queued.pop_front();
               tx_wait = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   // Check every accepted rsp beat against the oldest owed result, then draw a stall.
   // A requested freeze overrides the per-beat stall and drops ready for its length.
   always @(posedge clock) begin : receiver
      fupd_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (uri_results_due.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("rsp beat %0d unexpected: byte %02h valid %0b done %0b status %0d",
                           results_seen, rsp_data.out_byte, rsp_data.byte_valid,
                           rsp_data.done_res, rsp_data.status);
               mismatches++;
            end else begin
               want = uri_results_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.done_res !== want.done_res ||
                   rsp_data.status !== want.status) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("rsp beat %0d mismatch: expected byte %02h valid %0b done %0b status %0d",
                              results_seen, want.out_byte, want.byte_valid, want.done_res,
                              want.status);
                     $display("   got byte %02h valid %0b done %0b status %0d",
                              rsp_data.out_byte, rsp_data.byte_valid,
                              rsp_data.done_res, rsp_data.status);
                  end
                  mismatches++;
               end
            end
            results_seen++;
            rx_wait = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
         end
         if (rx_freeze > 0) begin
            rx_freeze--;
            rsp_ready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin : watchdog
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("file_uri_percent_decoder verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : sequencer
      logic [fupd_pkg::CAP_W-1:0] stage_caps [NUM_STAGES];
      int                         stage_target;
      // capacity per stage: zero, small edges from one to seven, the 17-bit maximum above the
      // clamp, the clamp itself, one below it, a random small buffer and the reset value
      stage_caps = '{17'd0, 17'd1, 17'd2, 17'd131071, 17'd3, 17'd65536, 17'd7,
                     17'd65535, 17'd4, 17'd4096};
      stage_caps[8] = fupd_pkg::CAP_W'($urandom_range(4, 24));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: clean path with both hex cases, NUL and 0xFF bytes; prefix mismatch;
      // empty string. Runs at the reset capacity.
      push_scheme(7);
      push_byte(fupd_pkg::CH_SLASH);
      push_byte(fupd_pkg::CH_PERCENT);
      push_byte("4");
      push_byte("a");
      push_byte(fupd_pkg::CH_PERCENT);
      push_byte("f");
      push_byte("F");
      push_byte(8'h00);
      push_byte(8'hFF);
      push_end();
      push_byte("g");
      push_end();
      push_end();
      wait_until_drained();

      // Random stages, one capacity each; write the register only once drained.
      for (int stage = 0; stage < NUM_STAGES; stage++) begin
         write_capacity(stage_caps[stage]);
         tx_gaps = (stage % 3) != 0;
         rx_gaps = (stage % 4) != 1;
         // freeze the receiver while the sender streams back to back: fill the block
         if (stage == 3) rx_freeze = FREEZE_CYCLES;
         stage_target = queued_items + STAGE_ITEMS;
         while (queued_items < stage_target) push_random_uri();
         wait_until_drained();
      end

      if (mismatches == 0 && uri_results_due.size() == 0) begin
         $display("file_uri_percent_decoder verification clean");
      end else begin
         $display("file_uri_percent_decoder verification failed");
      end
      $finish;
   end

endmodule
